FILE: sv/tttm_pkg.sv
// Shared types and constants of the tile-to-tileset matcher.
`default_nettype none

package tttm_pkg;

    // Fixed field widths
    localparam int PIXEL_W    = 32;
    localparam int INPUT_COLS = 8;
    localparam int COUNT_W    = 9;
    localparam int SLOT_IN_W  = 8;
    localparam int ROW_IN_W   = 3;
    localparam int INDEX_W    = 8;

    // Item operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_IMAGE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN,
        ST_FINISH
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic issue;
        logic publish;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic launch;
        logic count_zero;
        logic issue_last;
        logic hit;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/tttm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module tttm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/tttm_ctrl.sv
// Controller state machine that sequences the tileset search.
`default_nettype none

module tttm_ctrl
    import tttm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd,
    output logic            in_stall
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (status.launch)
                begin
                    state_next = status.count_zero ? ST_FINISH : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                priority if (status.hit)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.start = status.launch;
            end
            ST_SEARCH:
            begin
                cmd.issue = !status.hit;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_FINISH:
            begin
                cmd.publish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/tttm_datapath.sv
// Datapath: tileset store, image tile buffer, row compare and result register.
`default_nettype none

module tttm_datapath
    import tttm_pkg::*;
#(
    parameter int MAX_TILES = 256,
    parameter int TILE_ROWS = 8,
    parameter int TILE_COLS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_cmd_t              cmd,
    output dp_status_t                status,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic                 operation,
    input  wire logic [SLOT_IN_W-1:0] tile_slot,
    input  wire logic [ROW_IN_W-1:0]  tile_row,
    input  wire logic [PIXEL_W-1:0]   pixel_0,
    input  wire logic [PIXEL_W-1:0]   pixel_1,
    input  wire logic [PIXEL_W-1:0]   pixel_2,
    input  wire logic [PIXEL_W-1:0]   pixel_3,
    input  wire logic [PIXEL_W-1:0]   pixel_4,
    input  wire logic [PIXEL_W-1:0]   pixel_5,
    input  wire logic [PIXEL_W-1:0]   pixel_6,
    input  wire logic [PIXEL_W-1:0]   pixel_7,
    input  wire logic                 cfg_write_en,
    input  wire logic [COUNT_W-1:0]   cfg_write_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [INDEX_W-1:0]        match_index,
    output logic                      not_found
);

    localparam int SLOT_W     = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int ROW_W      = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
    localparam int TILE_DEPTH = MAX_TILES * TILE_ROWS;
    localparam int TADDR_W    = (TILE_DEPTH > 1) ? $clog2(TILE_DEPTH) : 1;
    localparam int ROW_BITS   = TILE_COLS * PIXEL_W;
    localparam int CHECK_W    = 5;

    // Configuration register
    logic [COUNT_W-1:0] tileset_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tileset_count_reg <= COUNT_W'(1);
        end
        else if (cfg_write_en)
        begin
            tileset_count_reg <= cfg_write_data;
        end
    end

    // Decode the incoming request
    logic accept;
    logic row_ok;
    logic slot_ok;
    logic row_last;

    assign accept   = in_valid && !in_stall;
    assign row_ok   = CHECK_W'(tile_row) < CHECK_W'(TILE_ROWS);
    assign slot_ok  = COUNT_W'(tile_slot) < COUNT_W'(MAX_TILES);
    assign row_last = CHECK_W'(tile_row) == CHECK_W'(TILE_ROWS - 1);

    logic              tile_we;
    logic              buf_we;
    logic [TADDR_W-1:0] tile_waddr;
    logic [ROW_W-1:0]  in_row;

    assign in_row     = ROW_W'(tile_row);
    assign tile_we    = accept && row_ok && (operation == OP_LOAD) && slot_ok;
    assign buf_we     = accept && row_ok && (operation == OP_IMAGE);
    assign tile_waddr = TADDR_W'(32'(tile_slot[SLOT_W-1:0]) * TILE_ROWS + 32'(in_row));

    // Assemble one pixel row; columns without an input pixel are zero
    logic [PIXEL_W-1:0]  pix_in [INPUT_COLS];
    logic [ROW_BITS-1:0] row_data;

    assign pix_in[0] = pixel_0;
    assign pix_in[1] = pixel_1;
    assign pix_in[2] = pixel_2;
    assign pix_in[3] = pixel_3;
    assign pix_in[4] = pixel_4;
    assign pix_in[5] = pixel_5;
    assign pix_in[6] = pixel_6;
    assign pix_in[7] = pixel_7;

    for (genvar c = 0; c < TILE_COLS; c++)
    begin : g_col
        if (c < INPUT_COLS)
        begin : g_pix
            assign row_data[c*PIXEL_W +: PIXEL_W] = pix_in[c];
        end
        else
        begin : g_zero
            assign row_data[c*PIXEL_W +: PIXEL_W] = '0;
        end
    end

    // Search address counters
    logic [SLOT_W-1:0]  a_slot_reg;
    logic [ROW_W-1:0]   a_row_reg;
    logic [SLOT_W-1:0]  lim_m1_reg;
    logic [COUNT_W-1:0] count_lim;
    logic               a_row_last;

    assign count_lim  = (tileset_count_reg > COUNT_W'(MAX_TILES)) ? COUNT_W'(MAX_TILES)
                                                                   : tileset_count_reg;
    assign a_row_last = a_row_reg == ROW_W'(TILE_ROWS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_slot_reg <= '0;
            a_row_reg  <= '0;
            lim_m1_reg <= '0;
        end
        else if (cmd.start)
        begin
            a_slot_reg <= '0;
            a_row_reg  <= '0;
            lim_m1_reg <= SLOT_W'(count_lim - COUNT_W'(1));
        end
        else if (cmd.issue)
        begin
            if (a_row_last)
            begin
                a_row_reg  <= '0;
                a_slot_reg <= a_slot_reg + SLOT_W'(1);
            end
            else
            begin
                a_row_reg <= a_row_reg + ROW_W'(1);
            end
        end
    end

    logic [TADDR_W-1:0] tile_raddr;

    assign tile_raddr = TADDR_W'(32'(a_slot_reg) * TILE_ROWS + 32'(a_row_reg));

    // Stores
    logic [ROW_BITS-1:0] tile_rdata;
    logic [ROW_BITS-1:0] buf_rdata;

    tttm_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (TILE_DEPTH)
    ) u_tile_ram (
        .clk     (clk),
        .wr_en   (tile_we),
        .wr_addr (tile_waddr),
        .wr_data (row_data),
        .rd_en   (cmd.issue),
        .rd_addr (tile_raddr),
        .rd_data (tile_rdata)
    );

    tttm_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (TILE_ROWS)
    ) u_buf_ram (
        .clk     (clk),
        .wr_en   (buf_we),
        .wr_addr (in_row),
        .wr_data (row_data),
        .rd_en   (cmd.issue),
        .rd_addr (a_row_reg),
        .rd_data (buf_rdata)
    );

    // Tag the read in flight
    logic              p_valid_reg;
    logic              p_first_reg;
    logic              p_last_reg;
    logic [SLOT_W-1:0] p_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= cmd.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            p_first_reg <= a_row_reg == '0;
            p_last_reg  <= a_row_last;
            p_slot_reg  <= a_slot_reg;
        end
    end

    // Compare rows and accumulate the slot match
    logic row_eq;
    logic slot_eq;
    logic hit;
    logic slot_ok_reg;

    assign row_eq  = tile_rdata == buf_rdata;
    assign slot_eq = row_eq && (p_first_reg || slot_ok_reg);
    assign hit     = p_valid_reg && p_last_reg && slot_eq;

    always_ff @(posedge clk)
    begin
        if (p_valid_reg)
        begin
            slot_ok_reg <= slot_eq;
        end
    end

    // Hold the search result
    logic              res_found_reg;
    logic [SLOT_W-1:0] res_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_found_reg <= 1'b0;
            res_slot_reg  <= '0;
        end
        else if (cmd.start)
        begin
            res_found_reg <= 1'b0;
            res_slot_reg  <= '0;
        end
        else if (hit)
        begin
            res_found_reg <= 1'b1;
            res_slot_reg  <= p_slot_reg;
        end
    end

    // Output register
    logic                out_valid_reg;
    logic [INDEX_W-1:0]  match_index_reg;
    logic                not_found_reg;
    logic                out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            match_index_reg <= INDEX_W'(res_slot_reg);
            not_found_reg   <= !res_found_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign match_index = match_index_reg;
    assign not_found   = not_found_reg;

    // Status to the controller
    assign status.launch     = buf_we && row_last;
    assign status.count_zero = tileset_count_reg == '0;
    assign status.issue_last = (a_slot_reg == lim_m1_reg) && a_row_last;
    assign status.hit        = hit;
    assign status.out_free   = out_free;

endmodule

`default_nettype wire

FILE: sv/tile_to_tileset_matcher_top.sv
// Top level of the tile-to-tileset matcher.
`default_nettype none

// Stores up to MAX_TILES tiles of TILE_ROWS x TILE_COLS RGBA pixels, one pixel
// row per memory word. Load requests (operation 0) write one row of a tileset
// slot and image requests (operation 1) write one row of the image tile buffer.
// The image request that carries the last row starts a search over slots 0 to
// tileset_count-1 (clamped to MAX_TILES). The search reads one tile row per
// cycle from the single read port of the tileset memory; input requests are
// stalled meanwhile. A count of zero reports not_found at once. The result
// (match_index, not_found) sits in an output register, so the next requests
// are taken while it waits for the consumer. Rows at or above TILE_ROWS and
// load slots at or above MAX_TILES are dropped. The user must write the
// tileset count through cfg_write_en / cfg_write_data only while the block
// idles; the block itself does not enforce it.
module tile_to_tileset_matcher_top
    import tttm_pkg::*;
#(
    parameter int MAX_TILES = 256,
    parameter int TILE_ROWS = 8,
    parameter int TILE_COLS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write_en,
    input  wire logic [COUNT_W-1:0]   cfg_write_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 operation,
    input  wire logic [SLOT_IN_W-1:0] tile_slot,
    input  wire logic [ROW_IN_W-1:0]  tile_row,
    input  wire logic [PIXEL_W-1:0]   pixel_0,
    input  wire logic [PIXEL_W-1:0]   pixel_1,
    input  wire logic [PIXEL_W-1:0]   pixel_2,
    input  wire logic [PIXEL_W-1:0]   pixel_3,
    input  wire logic [PIXEL_W-1:0]   pixel_4,
    input  wire logic [PIXEL_W-1:0]   pixel_5,
    input  wire logic [PIXEL_W-1:0]   pixel_6,
    input  wire logic [PIXEL_W-1:0]   pixel_7,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [INDEX_W-1:0]        match_index,
    output logic                      not_found
);

    dp_cmd_t    cmd;
    dp_status_t status;

    tttm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    tttm_datapath #(
        .MAX_TILES (MAX_TILES),
        .TILE_ROWS (TILE_ROWS),
        .TILE_COLS (TILE_COLS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .tile_slot      (tile_slot),
        .tile_row       (tile_row),
        .pixel_0        (pixel_0),
        .pixel_1        (pixel_1),
        .pixel_2        (pixel_2),
        .pixel_3        (pixel_3),
        .pixel_4        (pixel_4),
        .pixel_5        (pixel_5),
        .pixel_6        (pixel_6),
        .pixel_7        (pixel_7),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .match_index    (match_index),
        .not_found      (not_found)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tile_to_tileset_matcher_top_tb.sv
// Self-checking testbench for the tile-to-tileset matcher: tileset loads, image tiles, searches.
`timescale 1ns / 1ps

module tile_to_tileset_matcher_top_tb;
    import tttm_pkg::*;

    localparam int TILES       = 256;
    localparam int ROWS        = 8;
    localparam int COLS        = 8;
    localparam int NUM_PHASES  = 11;
    localparam int LOAD_SPAN   = 64;
    localparam int PHASE_ITEMS = 56;
    localparam int CYCLE_LIMIT = 10_000_000;

    typedef logic [INPUT_COLS-1:0][PIXEL_W-1:0] pix_row_t;
    typedef logic [ROWS-1:0][INPUT_COLS-1:0][PIXEL_W-1:0] tile_t;

    typedef struct packed {
        logic                 op;
        logic [SLOT_IN_W-1:0] slot;
        logic [ROW_IN_W-1:0]  row;
        pix_row_t             pix;
    } tile_req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               nf;
    } match_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write_en = 1'b0;
    logic [COUNT_W-1:0]   cfg_write_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 operation = 1'b0;
    logic [SLOT_IN_W-1:0] tile_slot = '0;
    logic [ROW_IN_W-1:0]  tile_row = '0;
    logic [PIXEL_W-1:0]   pixel_0 = '0;
    logic [PIXEL_W-1:0]   pixel_1 = '0;
    logic [PIXEL_W-1:0]   pixel_2 = '0;
    logic [PIXEL_W-1:0]   pixel_3 = '0;
    logic [PIXEL_W-1:0]   pixel_4 = '0;
    logic [PIXEL_W-1:0]   pixel_5 = '0;
    logic [PIXEL_W-1:0]   pixel_6 = '0;
    logic [PIXEL_W-1:0]   pixel_7 = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [INDEX_W-1:0]   match_index;
    logic                 not_found;

    // Predictor state: tileset, image buffer and searched count
    tile_t              pred_tiles [TILES];
    tile_t              pred_image;
    logic [COUNT_W-1:0] pred_count = COUNT_W'(1);

    // Stimulus shadow: what has been queued so far
    tile_t           gen_tiles [TILES];
    logic [ROWS-1:0] gen_loaded [TILES];
    logic [ROWS-1:0] gen_image_rows = '0;

    tile_req_t   pending_reqs [$];
    match_t      expected_matches [$];
    tile_req_t   live_req;
    match_t      want;

    int unsigned queued_items = 0;
    int unsigned loads_sent = 0;
    int unsigned images_sent = 0;
    int unsigned results_checked = 0;
    int unsigned hits_seen = 0;
    int unsigned misses_seen = 0;
    int unsigned fail_count = 0;
    int unsigned count_writes = 0;
    int unsigned cycle_count = 0;

    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    int unsigned run_left = 0;
    logic        stall_on = 1'b0;

    int unsigned phase_counts [NUM_PHASES];

    tile_to_tileset_matcher_top #(
        .MAX_TILES (TILES),
        .TILE_ROWS (ROWS),
        .TILE_COLS (COLS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .tile_slot      (tile_slot),
        .tile_row       (tile_row),
        .pixel_0        (pixel_0),
        .pixel_1        (pixel_1),
        .pixel_2        (pixel_2),
        .pixel_3        (pixel_3),
        .pixel_4        (pixel_4),
        .pixel_5        (pixel_5),
        .pixel_6        (pixel_6),
        .pixel_7        (pixel_7),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .match_index    (match_index),
        .not_found      (not_found)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Update the tileset or image buffer; a last image row yields the first matching slot
    task automatic predict_request(input tile_req_t req);
        int unsigned lim;
        match_t      found;
        if (req.op == OP_LOAD)
        begin
            pred_tiles[req.slot][req.row] = req.pix;
        end
        else
        begin
            pred_image[req.row] = req.pix;
            if (req.row == ROWS - 1)
            begin
                lim = (pred_count > TILES) ? TILES : pred_count;
                found.index = '0;
                found.nf = 1'b1;
                for (int s = 0; s < lim; s++)
                begin
                    if (found.nf && pred_tiles[s] == pred_image)
                    begin
                        found.index = INDEX_W'(s);
                        found.nf = 1'b0;
                    end
                end
                expected_matches.push_back(found);
            end
        end
    endtask

    function automatic pix_row_t rand_row();
        pix_row_t    row_v;
        int unsigned pick;
        for (int i = 0; i < INPUT_COLS; i++)
        begin
            pick = $urandom_range(0, 9);
            row_v[i] = (pick == 0) ? {PIXEL_W{1'b0}} :
                       (pick == 1) ? {PIXEL_W{1'b1}} : $urandom;
        end
        return row_v;
    endfunction

    // Queue one request and note what it leaves in the store
    task automatic queue_request(input logic op, input logic [SLOT_IN_W-1:0] slot,
                                 input logic [ROW_IN_W-1:0] row, input pix_row_t pix);
        tile_req_t req;
        req.op = op;
        req.slot = slot;
        req.row = row;
        req.pix = pix;
        pending_reqs.push_back(req);
        queued_items++;
        if (op == OP_LOAD)
        begin
            gen_tiles[slot][row] = pix;
            gen_loaded[slot][row] = 1'b1;
        end
        else
        begin
            gen_image_rows[row] = 1'b1;
        end
    endtask

    task automatic queue_tile_load(input logic [SLOT_IN_W-1:0] slot, input tile_t rows);
        for (int r = 0; r < ROWS; r++)
            queue_request(OP_LOAD, slot, ROW_IN_W'(r), rows[r]);
    endtask

    // Send the masked rows 0..6 in plain or shuffled order, then the last row
    task automatic queue_image_tile(input tile_t rows, input logic [ROWS-2:0] mask,
                                    input bit shuffled);
        int unsigned order [ROWS-1];
        int unsigned j;
        int unsigned tmp;
        for (int i = 0; i < ROWS - 1; i++)
            order[i] = i;
        if (shuffled)
        begin
            for (int i = ROWS - 2; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
        end
        // The buffer must be whole before its first search
        if (gen_image_rows[ROWS-2:0] != {(ROWS-1){1'b1}})
            mask = {(ROWS-1){1'b1}};
        for (int i = 0; i < ROWS - 1; i++)
        begin
            if (mask[order[i]])
                queue_request(OP_IMAGE, SLOT_IN_W'($urandom_range(0, 255)),
                              ROW_IN_W'(order[i]), rows[order[i]]);
        end
        queue_request(OP_IMAGE, SLOT_IN_W'($urandom_range(0, 255)), ROW_IN_W'(ROWS - 1),
                      rows[ROWS-1]);
    endtask

    // Hold until every request is taken and every result is back, then settle
    task automatic wait_drained(input int unsigned settle);
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_matches.size() != 0);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_tileset_count(input logic [COUNT_W-1:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        pred_count = value;
        count_writes++;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    // Driver: present queued requests in bursts with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_request(live_req);
                if (live_req.op == OP_LOAD)
                    loads_sent++;
                else
                    images_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    live_req = pending_reqs.pop_front();
                    operation <= live_req.op;
                    tile_slot <= live_req.slot;
                    tile_row <= live_req.row;
                    pixel_0 <= live_req.pix[0];
                    pixel_1 <= live_req.pix[1];
                    pixel_2 <= live_req.pix[2];
                    pixel_3 <= live_req.pix[3];
                    pixel_4 <= live_req.pix[4];
                    pixel_5 <= live_req.pix[5];
                    pixel_6 <= live_req.pix[6];
                    pixel_7 <= live_req.pix[7];
                    in_valid <= 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken result against the oldest expected match
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_matches.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: match_index %0d not_found %0b",
                                 match_index, not_found);
                    fail_count++;
                end
                else
                begin
                    want = expected_matches.pop_front();
                    results_checked++;
                    if (want.nf)
                        misses_seen++;
                    else
                        hits_seen++;
                    if (match_index !== want.index || not_found !== want.nf)
                    begin
                        if (fail_count < 10)
                            $display("result %0d: expected index %0d nf %0b, got index %0d nf %0b",
                                     results_checked, want.index, want.nf, match_index,
                                     not_found);
                        fail_count++;
                    end
                end
            end
            // Stall in modes: open, random, or long on/off runs
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(64, 256);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 2) == 0);
                default:
                begin
                    if (run_left == 0)
                    begin
                        stall_on = !stall_on;
                        run_left = $urandom_range(1, 12);
                    end
                    else
                    begin
                        run_left--;
                    end
                    out_stall <= stall_on;
                end
            endcase
        end
    end

    // Guard against a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_matches.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        tile_t       t0;
        tile_t       tile;
        pix_row_t    probe;
        logic [ROWS-2:0] mask;
        int unsigned s;
        int unsigned dst;
        int unsigned r;
        int unsigned c;
        int unsigned b;
        int unsigned pick;
        int unsigned span;
        int unsigned budget;
        bit          exact_only;

        for (int i = 0; i < TILES; i++)
            gen_loaded[i] = '0;
        phase_counts = '{4, 1, 9, 64, 256, 2, 16, 511, 6, 3, 300};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: slot 0 with all-zero and all-one rows, searched at the reset count
        t0 = '0;
        t0[1] = {(INPUT_COLS*PIXEL_W){1'b1}};
        for (int i = 2; i < ROWS; i++)
            t0[i] = rand_row();
        queue_tile_load(SLOT_IN_W'(0), t0);
        queue_image_tile(t0, {(ROWS-1){1'b1}}, 1'b0);
        // Incomplete tile: only the last row changes, one bit off, then restored
        probe = t0[ROWS-1];
        probe[3][0] = ~probe[3][0];
        queue_request(OP_IMAGE, 8'hFF, ROW_IN_W'(ROWS - 1), probe);
        queue_request(OP_IMAGE, 8'h00, ROW_IN_W'(ROWS - 1), t0[ROWS-1]);
        // Top slot, outside the searched range
        queue_request(OP_LOAD, 8'hFF, ROW_IN_W'(ROWS - 1), rand_row());
        wait_drained(20);

        // Count zero searches nothing even though slot 0 matches
        write_tileset_count('0);
        queue_request(OP_IMAGE, 8'h5A, ROW_IN_W'(ROWS - 1), t0[ROWS-1]);
        wait_drained(20);

        // Random phases over small, full and clamped counts
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_tileset_count(COUNT_W'(phase_counts[p]));
            // Past the loaded span only exact copies are searched, so each search hits early
            exact_only = phase_counts[p] > LOAD_SPAN;
            span = exact_only ? LOAD_SPAN : phase_counts[p];
            // Load every row the search can reach
            for (int i = 0; i < span; i++)
                for (int j = 0; j < ROWS; j++)
                    if (!gen_loaded[i][j])
                        queue_request(OP_LOAD, SLOT_IN_W'(i), ROW_IN_W'(j), rand_row());
            budget = queued_items + PHASE_ITEMS;
            while (queued_items < budget)
            begin
                s = $urandom_range(0, span - 1);
                pick = $urandom_range(0, 99);
                if (exact_only && (pick < 55 || pick >= 95))
                begin
                    queue_image_tile(gen_tiles[s], {(ROWS-1){1'b1}},
                                     $urandom_range(0, 2) == 0);
                end
                else if (pick < 40)
                begin
                    // Copy of a stored tile, sometimes one bit off
                    tile = gen_tiles[s];
                    if ($urandom_range(0, 3) == 0)
                    begin
                        r = $urandom_range(0, ROWS - 1);
                        c = $urandom_range(0, INPUT_COLS - 1);
                        b = $urandom_range(0, PIXEL_W - 1);
                        tile[r][c][b] = ~tile[r][c][b];
                    end
                    mask = ($urandom_range(0, 4) == 0) ? (ROWS-1)'($urandom)
                                                       : {(ROWS-1){1'b1}};
                    queue_image_tile(tile, mask, $urandom_range(0, 2) == 0);
                end
                else if (pick < 55)
                begin
                    for (int i = 0; i < ROWS; i++)
                        tile[i] = rand_row();
                    queue_image_tile(tile, {(ROWS-1){1'b1}}, 1'b0);
                end
                else if (pick < 65)
                begin
                    queue_request(OP_IMAGE, SLOT_IN_W'($urandom_range(0, 255)),
                                  ROW_IN_W'($urandom_range(0, ROWS - 2)), rand_row());
                end
                else if (pick < 80)
                begin
                    // Whole tile: a duplicate of another slot or fresh content
                    dst = $urandom_range(0, span - 1);
                    if ($urandom_range(0, 1) == 0)
                        tile = gen_tiles[s];
                    else
                        for (int i = 0; i < ROWS; i++)
                            tile[i] = rand_row();
                    queue_tile_load(SLOT_IN_W'(dst), tile);
                end
                else if (pick < 95)
                begin
                    dst = ($urandom_range(0, 4) == 0) ? $urandom_range(0, TILES - 1)
                                                      : $urandom_range(0, span - 1);
                    r = $urandom_range(0, ROWS - 1);
                    queue_request(OP_LOAD, SLOT_IN_W'(dst), ROW_IN_W'(r),
                                  ($urandom_range(0, 1) == 0) ? gen_tiles[s][r] : rand_row());
                end
                else
                begin
                    queue_request(OP_IMAGE, SLOT_IN_W'($urandom_range(0, 255)),
                                  ROW_IN_W'(ROWS - 1),
                                  ($urandom_range(0, 1) == 0) ? gen_tiles[s][ROWS-1]
                                                              : rand_row());
                end
            end
            wait_drained(20);
        end

        // Settle past the longest search to catch stray results
        wait_drained(2200);

        $display("Covered %0d loads and %0d image rows under %0d tileset count settings",
                 loads_sent, images_sent, count_writes + 1);
        $display("Checked %0d search results: %0d hits, %0d not found",
                 results_checked, hits_seen, misses_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
